// ===== src/fsla_pkg.sv =====
// ----------------------------------------------------------------------------
// fsla_pkg - shared types and constants of the frame store allocator
// Request and result beats, request and status codes, and the command and
// scan token structs that run between the controller and the frame cells.
// ----------------------------------------------------------------------------
package fsla_pkg;

  // Default geometry
  localparam int unsigned NUM_FRAMES      = 16;
  localparam int unsigned LINES_PER_FRAME = 3;
  localparam int unsigned LINE_WIDTH      = 32;

  // Fixed field widths
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned FRAME_W   = 4;
  localparam int unsigned OFFSET_W  = 2;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned TAG_W     = 8;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned STAMP_W   = 32;
  // Wide enough for the largest frame count
  localparam int unsigned SCAN_IDX_W = 8;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FREE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_VICTIM = 3'd4;
  localparam logic [MODE_W-1:0] MODE_OWNER  = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNALLOC = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NONE    = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd4;

  // Request beat
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [FRAME_W-1:0]  frame_sel;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   line_data;
    logic [TAG_W-1:0]    owner_id;
    logic [TAG_W-1:0]    page_index;
  } req_t;

  // Result beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame_out;
    logic [DATA_W-1:0]   line_out;
    logic [TAG_W-1:0]    owner_out;
    logic [TAG_W-1:0]    page_out;
    logic                owner_known;
  } rsp_t;

  // Direct command broadcast to all cells
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_READ,
    CMD_FREE,
    CMD_OWNER
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [FRAME_W-1:0]  frame_sel;
    logic [OFFSET_W-1:0] offset;
    logic [TAG_W-1:0]    owner;
    logic [TAG_W-1:0]    page;
    logic [STAMP_W-1:0]  stamp;
  } cell_cmd_t;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  alloc;
    logic                  found;
    logic [SCAN_IDX_W-1:0] best;
    logic [STAMP_W-1:0]    best_stamp;
    logic [TAG_W-1:0]      owner;
    logic [TAG_W-1:0]      page;
    logic                  known;
    logic [STAMP_W-1:0]    stamp_val;
  } scan_t;

endpackage

// ===== src/fsla_cell.sv =====
// ----------------------------------------------------------------------------
// fsla_cell - one frame of the store
// Holds busy, stamp, owner, page and line-filled bits of one frame, applies
// direct commands addressed to it, and updates the scan token on its way to
// the next cell (lowest free frame for allocate, oldest busy frame for victim).
// ----------------------------------------------------------------------------
module fsla_cell #(
  parameter int unsigned Index         = 0,
  parameter int unsigned LinesPerFrame = fsla_pkg::LINES_PER_FRAME
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fsla_pkg::cell_cmd_t      cmd_i,
  input  fsla_pkg::scan_t          scan_i,
  output fsla_pkg::scan_t          scan_o,
  output logic                     busy_o,
  output logic [LinesPerFrame-1:0] filled_o
);
  import fsla_pkg::*;

  localparam int unsigned OffW = (LinesPerFrame > 1) ? $clog2(LinesPerFrame) : 1;

  logic                     busy_q;
  logic [STAMP_W-1:0]       stamp_q;
  logic [TAG_W-1:0]         owner_q;
  logic [TAG_W-1:0]         page_q;
  logic                     known_q;
  logic [LinesPerFrame-1:0] filled_q;
  scan_t                    scan_d, scan_q;
  logic                     hit;
  logic                     claim;
  logic                     take;

  assign hit   = (int'(cmd_i.frame_sel) == int'(Index));
  assign claim = scan_i.valid && scan_i.alloc && !scan_i.found && !busy_q;
  assign take  = scan_i.valid && !scan_i.alloc && busy_q &&
                 (!scan_i.found || (stamp_q < scan_i.best_stamp));

  // Update the token as it passes
  always_comb begin
    scan_d = scan_i;
    if (claim) begin
      scan_d.found = 1'b1;
      scan_d.best  = SCAN_IDX_W'(Index);
    end else if (take) begin
      scan_d.found      = 1'b1;
      scan_d.best       = SCAN_IDX_W'(Index);
      scan_d.best_stamp = stamp_q;
      scan_d.owner      = owner_q;
      scan_d.page       = page_q;
      scan_d.known      = known_q;
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  // Apply direct commands and allocation claims
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      stamp_q  <= '0;
      owner_q  <= '0;
      page_q   <= '0;
      known_q  <= 1'b0;
      filled_q <= '0;
    end else if (claim) begin
      busy_q  <= 1'b1;
      stamp_q <= scan_i.stamp_val;
    end else if (hit) begin
      unique case (cmd_i.op)
        CMD_WRITE: begin
          stamp_q                       <= cmd_i.stamp;
          filled_q[OffW'(cmd_i.offset)] <= 1'b1;
        end
        CMD_READ: begin
          stamp_q <= cmd_i.stamp;
        end
        CMD_FREE: begin
          busy_q   <= 1'b0;
          stamp_q  <= '0;
          filled_q <= '0;
        end
        CMD_OWNER: begin
          owner_q <= cmd_i.owner;
          page_q  <= cmd_i.page;
          known_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign scan_o   = scan_q;
  assign busy_o   = busy_q;
  assign filled_o = filled_q;

endmodule

// ===== src/frame_store_lru_allocator_core.sv =====
// ----------------------------------------------------------------------------
// frame_store_lru_allocator_core - frame store with LRU victim selection
// Controller, line word memory and a chain of frame cells. Allocate and
// victim requests send a token down the cell chain; other requests act on
// the addressed frame directly.
// ----------------------------------------------------------------------------
//  channel   ports                    direction  handshake
//  request   start, req_i, busy       in         start && !busy
//  result    valid_o, rsp_o           out        valid_o, one cycle
//
//  Write, read, free, set owner and unknown modes step through execute,
//  memory read and result beat before the next accept.
//  Allocate and find victim: the result beat waits for the token walking
//  the cell chain one frame per cycle.
//  busy is high from the accept until the result beat; the result beat is
//  held for exactly one cycle and cannot be stalled.
//  Reset clears all frame state and the touch counter at once; line words
//  are guarded by the per-frame filled bits.
// ----------------------------------------------------------------------------
module frame_store_lru_allocator_core #(
  parameter int unsigned NumFrames     = fsla_pkg::NUM_FRAMES,
  parameter int unsigned LinesPerFrame = fsla_pkg::LINES_PER_FRAME,
  parameter int unsigned LineWidth     = fsla_pkg::LINE_WIDTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  fsla_pkg::req_t req_i,
  output logic           busy,
  output logic           valid_o,
  output fsla_pkg::rsp_t rsp_o
);
  import fsla_pkg::*;

  localparam int unsigned TotalLines = NumFrames * LinesPerFrame;
  localparam int unsigned FIdxW = (NumFrames > 1) ? $clog2(NumFrames) : 1;
  localparam int unsigned OffW  = (LinesPerFrame > 1) ? $clog2(LinesPerFrame) : 1;
  localparam int unsigned LIdxW = (TotalLines > 1) ? $clog2(TotalLines) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0]               state_q, state_d;
  req_t                     req_q;
  logic [STAMP_W-1:0]       ctr_q;
  logic                     ctr_inc;
  logic [STATUS_W-1:0]      status_q, status_d;
  logic                     rd_hit_q, rd_hit_d;
  logic                     valid_q, valid_d;
  rsp_t                     rsp_q, rsp_d;

  cell_cmd_t                cmd;
  scan_t                    head;
  scan_t                    chain [NumFrames];
  scan_t                    tail;
  logic                     busy_vec [NumFrames];
  logic [LinesPerFrame-1:0] filled_arr [NumFrames];

  logic [FIdxW-1:0]         fidx;
  logic [LIdxW-1:0]         lidx;
  logic                     f_ok, off_ok;
  logic                     sel_busy, sel_filled;

  logic [LineWidth-1:0]     line_mem [TotalLines];
  logic [LineWidth-1:0]     rdata_q;
  logic                     mem_we, mem_re;

  // Address decode of the held request
  assign fidx   = FIdxW'(req_q.frame_sel);
  assign f_ok   = int'(req_q.frame_sel) < int'(NumFrames);
  assign off_ok = int'(req_q.offset) < int'(LinesPerFrame);
  assign lidx   = LIdxW'(fidx) * LIdxW'(LinesPerFrame) + LIdxW'(req_q.offset);
  assign sel_busy   = busy_vec[fidx];
  assign sel_filled = filled_arr[fidx][OffW'(req_q.offset)];
  assign tail       = chain[NumFrames-1];

  // Frame cell chain
  for (genvar g = 0; g < NumFrames; g++) begin : g_cell
    fsla_cell #(
      .Index        (g),
      .LinesPerFrame(LinesPerFrame)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .scan_i  ((g == 0) ? head : chain[(g == 0) ? 0 : g - 1]),
      .scan_o  (chain[g]),
      .busy_o  (busy_vec[g]),
      .filled_o(filled_arr[g])
    );
  end

  // Sequence requests, build commands and result beats
  always_comb begin
    state_d       = state_q;
    status_d      = status_q;
    rd_hit_d      = 1'b0;
    ctr_inc       = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    valid_d       = 1'b0;
    rsp_d         = rsp_q;
    cmd           = '0;
    cmd.op        = CMD_NONE;
    cmd.frame_sel = req_q.frame_sel;
    cmd.offset    = req_q.offset;
    cmd.owner     = req_q.owner_id;
    cmd.page      = req_q.page_index;
    cmd.stamp     = ctr_q;
    head           = '0;
    head.alloc     = (req_q.mode == MODE_ALLOC);
    head.stamp_val = ctr_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d  = S_FIN;
        status_d = STATUS_OK;
        case (req_q.mode) inside
          MODE_ALLOC, MODE_VICTIM: begin
            head.valid = 1'b1;
            state_d    = S_SCAN;
          end
          MODE_WRITE, MODE_READ: begin
            if (!f_ok || !off_ok) begin
              status_d = STATUS_RANGE;
            end else if (!sel_busy) begin
              status_d = STATUS_UNALLOC;
            end else begin
              ctr_inc = 1'b1;
              if (req_q.mode == MODE_WRITE) begin
                cmd.op = CMD_WRITE;
                mem_we = 1'b1;
              end else begin
                cmd.op = CMD_READ;
                if (sel_filled) begin
                  mem_re   = 1'b1;
                  rd_hit_d = 1'b1;
                end else begin
                  status_d = STATUS_EMPTY;
                end
              end
            end
          end
          MODE_FREE: begin
            if (!f_ok) begin
              status_d = STATUS_RANGE;
            end else if (!sel_busy) begin
              status_d = STATUS_UNALLOC;
            end else begin
              cmd.op = CMD_FREE;
            end
          end
          MODE_OWNER: begin
            if (!f_ok) begin
              status_d = STATUS_RANGE;
            end else begin
              cmd.op = CMD_OWNER;
            end
          end
          default: begin
            status_d = STATUS_RANGE;
          end
        endcase
      end
      S_FIN: begin
        state_d           = S_IDLE;
        valid_d           = 1'b1;
        rsp_d             = '0;
        rsp_d.status      = status_q;
        rsp_d.line_out    = rd_hit_q ? DATA_W'(rdata_q) : '0;
      end
      S_SCAN: begin
        if (tail.valid) begin
          state_d = S_IDLE;
          valid_d = 1'b1;
          rsp_d   = '0;
          if (!tail.found) begin
            rsp_d.status = STATUS_NONE;
          end else begin
            rsp_d.status    = STATUS_OK;
            rsp_d.frame_out = FRAME_W'(tail.best);
            if (tail.alloc) begin
              ctr_inc = 1'b1;
            end else begin
              rsp_d.owner_out   = tail.owner;
              rsp_d.page_out    = tail.page;
              rsp_d.owner_known = tail.known;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ctr_q    <= '0;
      valid_q  <= 1'b0;
      status_q <= STATUS_OK;
      rd_hit_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      status_q <= status_d;
      rd_hit_q <= rd_hit_d;
      if (ctr_inc) begin
        ctr_q <= ctr_q + STAMP_W'(1);
      end
    end
  end

  // Capture the request beat and the result payload
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  // Line word memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[lidx] <= LineWidth'(req_q.line_data);
    end
    if (mem_re) begin
      rdata_q <= line_mem[lidx];
    end
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  // Checks
  a_result_follows_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result beat without a request in progress");

  a_accept_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_token_only_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> (state_q == S_SCAN))
    else $error("scan token left the chain outside a scan");

  a_counter_steps_by_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctr_q != $past(ctr_q)) |-> (ctr_q == $past(ctr_q) + STAMP_W'(1)))
    else $error("touch counter jumped");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for frame_store_lru_allocator_core
// Sends request beats with random gaps and predicts each result beat from a
// behavioral frame store kept in a scoreboard class. It covers allocation
// until full, line writes and reads, frees, victim search and owner tags.
// ----------------------------------------------------------------------------
module testbench;
  import fsla_pkg::*;

  // Modes the block does not define; both must come back as out of range
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  localparam int unsigned TOTAL_LINES = NUM_FRAMES * LINES_PER_FRAME;
  localparam int unsigned IDLE_LIMIT  = 1000;
  localparam int unsigned TAIL_CYCLES = NUM_FRAMES + 8;
  localparam int unsigned ROUNDS      = 13;
  localparam int unsigned ROUND_BEATS = 50;

  // Request mixes of the random rounds
  typedef enum int {MIX_FILL, MIX_STEADY, MIX_DRAIN} mix_e;

  // --------------------------------------------------------------------------
  // Scoreboard: frame store predictor and queue of expected result beats
  // --------------------------------------------------------------------------
  class fsla_scoreboard;
    bit              in_use    [NUM_FRAMES];
    bit [STAMP_W-1:0] stamp    [NUM_FRAMES];
    bit              filled    [TOTAL_LINES];
    bit [DATA_W-1:0] words     [TOTAL_LINES];
    bit [TAG_W-1:0]  owner_tag [NUM_FRAMES];
    bit [TAG_W-1:0]  page_tag  [NUM_FRAMES];
    bit              tag_valid [NUM_FRAMES];
    bit [STAMP_W-1:0] touch_count;

    rsp_t expected_rsp[$];
    int   errors;
    int   n_req, n_rsp, n_full, n_victim, n_empty_read, n_hit_read, n_reject;

    // Print one line per mismatch and count it
    task report(input string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      errors++;
    endtask

    function void touch(input int f);
      stamp[f]    = touch_count;
      touch_count = touch_count + STAMP_W'(1);
    endfunction

    // Work out the result of one accepted request and queue it
    function void predict_response(input req_t r);
      rsp_t e;
      int   idx;
      bit   found;
      int   best;
      e        = '0;
      e.status = STATUS_OK;
      idx      = int'(r.frame_sel) * LINES_PER_FRAME + int'(r.offset);
      n_req++;
      case (r.mode) inside
        MODE_ALLOC: begin
          e.status = STATUS_NONE;
          for (int i = 0; i < NUM_FRAMES; i++) begin
            if (!in_use[i]) begin
              in_use[i]   = 1'b1;
              touch(i);
              e.status    = STATUS_OK;
              e.frame_out = FRAME_W'(i);
              break;
            end
          end
          if (e.status == STATUS_NONE) n_full++;
        end
        MODE_WRITE, MODE_READ: begin
          if (r.frame_sel >= NUM_FRAMES || r.offset >= LINES_PER_FRAME) begin
            e.status = STATUS_RANGE;
          end else if (!in_use[r.frame_sel]) begin
            e.status = STATUS_UNALLOC;
          end else begin
            touch(r.frame_sel);
            if (r.mode == MODE_WRITE) begin
              words[idx]  = r.line_data;
              filled[idx] = 1'b1;
            end else if (filled[idx]) begin
              e.line_out = words[idx];
              n_hit_read++;
            end else begin
              e.status = STATUS_EMPTY;
              n_empty_read++;
            end
          end
        end
        MODE_FREE: begin
          if (r.frame_sel >= NUM_FRAMES) begin
            e.status = STATUS_RANGE;
          end else if (!in_use[r.frame_sel]) begin
            e.status = STATUS_UNALLOC;
          end else begin
            // Keep owner and page; drop stamp and line contents
            in_use[r.frame_sel] = 1'b0;
            stamp[r.frame_sel]  = '0;
            for (int i = 0; i < LINES_PER_FRAME; i++)
              filled[int'(r.frame_sel) * LINES_PER_FRAME + i] = 1'b0;
          end
        end
        MODE_VICTIM: begin
          found = 1'b0;
          best  = 0;
          // Lowest frame wins a tie on the stamp
          for (int i = 0; i < NUM_FRAMES; i++) begin
            if (in_use[i] && (!found || stamp[i] < stamp[best])) begin
              found = 1'b1;
              best  = i;
            end
          end
          if (!found) begin
            e.status = STATUS_NONE;
          end else begin
            e.frame_out   = FRAME_W'(best);
            e.owner_out   = owner_tag[best];
            e.page_out    = page_tag[best];
            e.owner_known = tag_valid[best];
            n_victim++;
          end
        end
        MODE_OWNER: begin
          if (r.frame_sel >= NUM_FRAMES) begin
            e.status = STATUS_RANGE;
          end else begin
            owner_tag[r.frame_sel] = r.owner_id;
            page_tag[r.frame_sel]  = r.page_index;
            tag_valid[r.frame_sel] = 1'b1;
          end
        end
        default: begin
          e.status = STATUS_RANGE;
          n_reject++;
        end
      endcase
      expected_rsp.push_back(e);
    endfunction

    // Compare a result beat with the oldest expectation
    task check_response(input rsp_t got);
      rsp_t e;
      n_rsp++;
      if (expected_rsp.size() == 0) begin
        report($sformatf("result beat with nothing expected: %h", got));
      end else begin
        e = expected_rsp.pop_front();
        if (got.status !== e.status)
          report($sformatf("status exp %0d got %0d", e.status, got.status));
        if (got.frame_out !== e.frame_out)
          report($sformatf("frame_out exp %0d got %0d", e.frame_out, got.frame_out));
        if (got.line_out !== e.line_out)
          report($sformatf("line_out exp %h got %h", e.line_out, got.line_out));
        if (got.owner_out !== e.owner_out)
          report($sformatf("owner_out exp %h got %h", e.owner_out, got.owner_out));
        if (got.page_out !== e.page_out)
          report($sformatf("page_out exp %h got %h", e.page_out, got.page_out));
        if (got.owner_known !== e.owner_known)
          report($sformatf("owner_known exp %0d got %0d", e.owner_known, got.owner_known));
      end
    endtask

    function int pending();
      return expected_rsp.size();
    endfunction

    // Flag every expectation that never got its result beat
    task check_leftovers();
      while (expected_rsp.size() != 0) begin
        report($sformatf("missing result beat, expected %h", expected_rsp.pop_front()));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic valid_o;
  rsp_t rsp_o;

  fsla_scoreboard frame_sb = new();
  int unsigned    idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  frame_store_lru_allocator_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  // Check the result beat before noting a request taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) frame_sb.check_response(rsp_o);
      if (start && !busy) frame_sb.predict_response(req_i);
    end
  end

  // Stop the run when no beat moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("frame_store_lru_allocator_core verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap(input bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic req_t make_req(input logic [MODE_W-1:0] mode,
                                    input logic [FRAME_W-1:0] frame,
                                    input logic [OFFSET_W-1:0] offset,
                                    input logic [DATA_W-1:0] data,
                                    input logic [TAG_W-1:0] owner,
                                    input logic [TAG_W-1:0] page);
    req_t r;
    r.mode       = mode;
    r.frame_sel  = frame;
    r.offset     = offset;
    r.line_data  = data;
    r.owner_id   = owner;
    r.page_index = page;
    return r;
  endfunction

  // Random request; low frames are favored since allocation fills from 0
  function automatic req_t random_req(input mix_e mix);
    req_t r;
    int   roll;
    int   n_alloc, n_write, n_read, n_free, n_victim;
    case (mix)
      MIX_FILL:  begin n_alloc = 30; n_write = 25; n_read = 20; n_free = 5;  end
      MIX_DRAIN: begin n_alloc = 4;  n_write = 20; n_read = 20; n_free = 36; end
      default:   begin n_alloc = 12; n_write = 28; n_read = 28; n_free = 12; end
    endcase
    n_victim = 10;
    roll = $urandom_range(0, 99);
    if (roll < n_alloc)                                     r.mode = MODE_ALLOC;
    else if (roll < n_alloc + n_write)                      r.mode = MODE_WRITE;
    else if (roll < n_alloc + n_write + n_read)             r.mode = MODE_READ;
    else if (roll < n_alloc + n_write + n_read + n_free)    r.mode = MODE_FREE;
    else if (roll < n_alloc + n_write + n_read + n_free + n_victim)
      r.mode = MODE_VICTIM;
    else if (roll < 98)                                     r.mode = MODE_OWNER;
    else r.mode = $urandom_range(0, 1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
    r.frame_sel  = $urandom_range(0, 1) ? $urandom_range(0, NUM_FRAMES - 1)
                                        : $urandom_range(0, NUM_FRAMES / 2 - 1);
    r.offset     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                                               : $urandom_range(0, LINES_PER_FRAME - 1);
    r.line_data  = $urandom();
    r.owner_id   = $urandom_range(0, 255);
    r.page_index = $urandom_range(0, 255);
    return r;
  endfunction

  // Hold the request until accepted, then idle for the given gap
  task automatic issue_req(input req_t r, input int gap);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    mix_e mix;
    bit   quiet;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty store, unallocated frames, range, full store, victim
    issue_req(make_req(MODE_VICTIM, '0, '0, '0, '0, '0), pick_gap(1'b0));
    issue_req(make_req(MODE_READ, '0, '0, '0, '0, '0), pick_gap(1'b0));
    issue_req(make_req(MODE_FREE, 4'hf, '0, '0, '0, '0), pick_gap(1'b0));
    issue_req(make_req(MODE_OWNER, 4'hf, '0, '0, 8'hff, 8'h00), pick_gap(1'b0));
    issue_req(make_req(MODE_ALLOC, '0, '0, '0, '0, '0), pick_gap(1'b0));
    issue_req(make_req(MODE_READ, '0, '0, '0, '0, '0), pick_gap(1'b0));
    issue_req(make_req(MODE_WRITE, '0, '0, '1, '1, '1), pick_gap(1'b0));
    issue_req(make_req(MODE_WRITE, '0, 2'd3, 32'h5a5a_a5a5, '0, '0), pick_gap(1'b0));
    issue_req(make_req(MODE_READ, '0, '0, '0, '0, '0), pick_gap(1'b0));
    issue_req(make_req(MODE_UNUSED_LO, 4'hf, 2'd3, '1, '1, '1), pick_gap(1'b0));
    issue_req(make_req(MODE_UNUSED_HI, '0, '0, '0, '0, '0), pick_gap(1'b0));
    issue_req(make_req(MODE_OWNER, '0, '0, '0, 8'h00, 8'hff), pick_gap(1'b0));
    // Fill every frame, then one more allocate finds the store full
    repeat (NUM_FRAMES) issue_req(make_req(MODE_ALLOC, '0, '0, '0, '0, '0), pick_gap(1'b1));
    issue_req(make_req(MODE_VICTIM, '0, '0, '0, '0, '0), pick_gap(1'b0));
    issue_req(make_req(MODE_FREE, '0, '0, '0, '0, '0), pick_gap(1'b0));
    issue_req(make_req(MODE_VICTIM, '0, '0, '0, '0, '0), pick_gap(1'b0));
    issue_req(make_req(MODE_ALLOC, '0, '0, '0, '0, '0), pick_gap(1'b0));

    // Random rounds cycling through fill, steady and drain mixes
    for (int rnd = 0; rnd < ROUNDS; rnd++) begin
      case (rnd % 4)
        0:       mix = MIX_FILL;
        2:       mix = MIX_DRAIN;
        default: mix = MIX_STEADY;
      endcase
      quiet = (rnd % 5 == 4);
      repeat (ROUND_BEATS) issue_req(random_req(mix), pick_gap(quiet));
    end
    start <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (frame_sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    frame_sb.check_leftovers();

    $display("covered %0d requests, %0d result beats, %0d store-full allocates",
             frame_sb.n_req, frame_sb.n_rsp, frame_sb.n_full);
    $display("victims found %0d, reads hit %0d, empty reads %0d, unknown modes %0d",
             frame_sb.n_victim, frame_sb.n_hit_read, frame_sb.n_empty_read,
             frame_sb.n_reject);
    if (frame_sb.errors == 0) begin
      $display("frame_store_lru_allocator_core verification clean");
    end else begin
      $display("frame_store_lru_allocator_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/fsla_pkg.sv
src/fsla_cell.sv
src/frame_store_lru_allocator_core.sv
bench/testbench.sv
